[design/assert_macros.svh]
// Assertion macros shared by the window sum peak counter RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define SWPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("window_sum_peak_counter check failed");

// Next-cycle implication under an active-low reset.
`define SWPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("window_sum_peak_counter check failed");

`endif

[design/swpc_pkg.sv]
// Types and fixed widths for the window sum peak counter.
// No dependencies; imported by the top level and by swpc_cnt_cell.
package swpc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SUM_W     = 26;
	localparam int CNT_W     = 32;
	localparam int LEN_W     = 11;
	localparam int CELL_W    = 8;
	localparam int N_CELLS   = CNT_W / CELL_W;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                is_last;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] best_sum;
		logic [CNT_W-1:0] best_count;
		logic             all_zero;
		logic             too_short;
	} result_t;

	// Command fanned out to every hit-count cell.
	typedef struct packed {
		logic clr;
		logic set;
	} cnt_cmd_t;

endpackage

[design/swpc_ring.sv]
// Sample ring: one write port and one registered read port.
// Depends on nothing but its parameters; no reset on the storage.
module swpc_ring #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];

	// Read returns the old entry when both ports hit the same address.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

[design/swpc_cnt_cell.sv]
// One slice of the saturating hit counter; cells chain carry and all-ones.
// Depends on swpc_pkg for the command struct.
module swpc_cnt_cell import swpc_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cnt_cmd_t     cmd,
	input  logic         set_lsb,
	input  logic         carry_in,
	input  logic         ones_in,
	output logic         carry_out,
	output logic         ones_out,
	output logic [W-1:0] cnt_upd
);

	logic [W-1:0] cnt_q;
	logic         full_slice;

	assign full_slice = &cnt_q;
	assign carry_out  = carry_in & full_slice;
	assign ones_out   = ones_in & full_slice;

	always_comb begin
		if (cmd.set) begin
			cnt_upd = W'(set_lsb);
		end else if (carry_in) begin
			cnt_upd = cnt_q + W'(1);
		end else begin
			cnt_upd = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_upd;
		end
	end

endmodule

[design/window_sum_peak_counter.sv]
// Sliding window sum with peak value and saturating peak hit count.
// Depends on swpc_pkg, swpc_ring, swpc_cnt_cell and assert_macros.svh.
//
//   channel   signals                               direction
//   item      item_valid, item_ready, item         in  (sample, is_last)
//   result    result_valid, result_ready, result   out (one beat per last)
//   config    cfg_wr_en, cfg_wr_data               in  (window_len, no wait)
//
// One beat per cycle while item_ready is high; a last beat's result passes the
// ring read (stage 1), window add-subtract (stage 2), peak compare and count update.
// The ring has no clearing pass; only control registers reset (window_len to 1).
// Input stalls only while a last beat sits in the compare stage and the output
// register still holds an untaken result.
`include "assert_macros.svh"

module window_sum_peak_counter import swpc_pkg::*; #(
	parameter int WINDOW_MAX = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
	localparam logic [CW-1:0] WMAX_C    = CW'(WINDOW_MAX);
	localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_MAX - 1);

	// configuration and fill control
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] fill_q;
	logic [AW-1:0]    slot_q;
	logic [CW-1:0]    win_len;
	logic [CW-1:0]    fill_ext;
	logic [CW-1:0]    fill_inc;
	logic [CW-1:0]    slot_ext;
	logic [CW-1:0]    old_idx;
	logic             adv;
	logic             accept;
	logic             is_full;
	logic             is_first;
	logic             is_short;

	// stage 1
	logic                s1_valid_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                last_s1;
	logic                full_s1;
	logic                first_s1;
	logic                short_s1;
	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    win_sum_q;
	logic [SUM_W-1:0]    sum_new;

	// stage 2
	logic             s2_valid_q;
	logic [SUM_W-1:0] sum_s2;
	logic             last_s2;
	logic             full_s2;
	logic             first_s2;
	logic             short_s2;
	logic [SUM_W-1:0] peak_q;
	logic [SUM_W-1:0] peak_upd;
	logic             s2_go;
	logic             set_peak;
	logic             inc_en;
	logic             sat;
	logic [CNT_W-1:0] hits_upd;
	cnt_cmd_t         cnt_cmd;
	logic [N_CELLS:0] carry_chain;
	logic [N_CELLS:0] ones_chain;

	// output
	logic    out_valid_q;
	result_t result_q;
	result_t result_d;
	logic    short_clean;
	logic    count_live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	// zero acts as one, clip to ring depth
	always_comb begin
		if (len_q == '0) begin
			win_len = CW'(1);
		end else if (CW'(len_q) > WMAX_C) begin
			win_len = WMAX_C;
		end else begin
			win_len = CW'(len_q);
		end
	end

	assign adv        = !(s2_valid_q && last_s2 && out_valid_q && !result_ready);
	assign item_ready = adv;
	assign accept     = item_valid && adv;

	assign fill_ext = CW'(fill_q);
	assign fill_inc = fill_ext + CW'(1);
	assign is_full  = fill_ext >= win_len;
	assign is_first = !is_full && (fill_inc == win_len);
	assign is_short = !is_full && (fill_inc < win_len);
	assign slot_ext = CW'(slot_q);
	assign old_idx  = (slot_ext >= win_len) ? slot_ext - win_len
	                                        : slot_ext + WMAX_C - win_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (item.is_last) begin
				fill_q <= '0;
				slot_q <= '0;
			end else begin
				if (!is_full) begin
					fill_q <= fill_inc[LEN_W-1:0];
				end
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + AW'(1);
			end
		end
	end

	swpc_ring #(
		.DEPTH (WINDOW_MAX),
		.AW    (AW),
		.DW    (SAMPLE_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (slot_q),
		.wr_data (item.sample),
		.rd_en   (accept),
		.rd_addr (old_idx[AW-1:0]),
		.rd_data (old_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= item.sample;
			last_s1   <= item.is_last;
			full_s1   <= is_full;
			first_s1  <= is_first;
			short_s1  <= is_short;
		end
	end

	// add the new sample, drop the oldest once the window is full
	assign sum_new = win_sum_q + SUM_W'(sample_s1)
	                 - (full_s1 ? SUM_W'(old_sample) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			win_sum_q  <= '0;
		end else if (adv) begin
			s2_valid_q <= s1_valid_q;
			if (s1_valid_q) begin
				win_sum_q <= last_s1 ? '0 : sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			sum_s2   <= sum_new;
			last_s2  <= last_s1;
			full_s2  <= full_s1;
			first_s2 <= first_s1;
			short_s2 <= short_s1;
		end
	end

	assign s2_go    = adv && s2_valid_q;
	assign set_peak = s2_go && (first_s2 || (full_s2 && (sum_s2 > peak_q)));
	assign sat      = ones_chain[N_CELLS];
	assign inc_en   = s2_go && full_s2 && (sum_s2 == peak_q) && !sat;
	assign peak_upd = set_peak ? sum_s2 : peak_q;

	assign cnt_cmd.set = set_peak;
	assign cnt_cmd.clr = s2_go && last_s2;

	assign carry_chain[0] = inc_en;
	assign ones_chain[0]  = 1'b1;

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cnt
		swpc_cnt_cell #(
			.W (CELL_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cnt_cmd),
			.set_lsb   (i == 0),
			.carry_in  (carry_chain[i]),
			.ones_in   (ones_chain[i]),
			.carry_out (carry_chain[i+1]),
			.ones_out  (ones_chain[i+1]),
			.cnt_upd   (hits_upd[i*CELL_W +: CELL_W])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (s2_go) begin
			peak_q <= last_s2 ? '0 : peak_upd;
		end
	end

	always_comb begin
		if (short_s2) begin
			result_d.best_sum   = '0;
			result_d.best_count = '0;
			result_d.all_zero   = 1'b0;
			result_d.too_short  = 1'b1;
		end else begin
			result_d.best_sum   = peak_upd;
			result_d.best_count = hits_upd;
			result_d.all_zero   = (peak_upd == '0);
			result_d.too_short  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && last_s2) begin
			result_q <= result_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	assign short_clean = (result.best_sum == '0) && (result.best_count == '0)
	                     && !result.all_zero;
	assign count_live  = (result.best_count != '0);

	`SWPC_ASSERT_NOW(a_stall_cause, clk, arst_n, !item_ready, result_valid && !result_ready)
	`SWPC_ASSERT_NOW(a_slot_range, clk, arst_n, 1'b1, CW'(slot_q) < WMAX_C)
	`SWPC_ASSERT_NOW(a_short_zero, clk, arst_n, result_valid && result.too_short, short_clean)
	`SWPC_ASSERT_NOW(a_count_live, clk, arst_n, result_valid && !result.too_short, count_live)

endmodule

[bench/tb_window_sum_peak_counter.sv]
// Self-checking bench for window_sum_peak_counter: streams of samples in, peak results out.
// Depends on swpc_pkg and the RTL; a clocked driver and monitor check each result against
// an in-bench sliding-window predictor.
module tb_window_sum_peak_counter;
	import swpc_pkg::*;

	localparam int RING_DEPTH  = 1024;
	localparam int SLOT_W      = 10;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_TAIL  = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1250;
	localparam int MIN_PHASES  = 4;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum int {MIX_RANDOM, MIX_SMALL, MIX_ZERO, MIX_EXTREME, MIX_NEAR_MAX} sample_mix_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	item_t            item = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;

	item_t   samples_pending[$];
	result_t peaks_due[$];
	bit      item_acc = 1'b0;
	int      snd_idle_pct = 0;
	int      rcv_stall_pct = 0;
	bit      hold_go = 1'b0;
	int      hold_left = 0;
	int      mismatches = 0;
	int      cycles = 0;
	int      queued = 0;

	// predictor state
	logic [LEN_W-1:0]    len_cfg = LEN_RESET;
	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [SUM_W-1:0]    win_sum = '0;
	logic [LEN_W-1:0]    fill = '0;
	logic [SLOT_W-1:0]   slot = '0;
	logic [SUM_W-1:0]    peak = '0;
	logic [CNT_W-1:0]    hits = '0;

	window_sum_peak_counter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// zero acts as one, anything past the ring depth saturates
	function automatic logic [LEN_W-1:0] span_of(input logic [LEN_W-1:0] v);
		if (v == '0)
			return LEN_W'(1);
		if (v > LEN_W'(RING_DEPTH))
			return LEN_W'(RING_DEPTH);
		return v;
	endfunction

	function automatic bit advance_window(input item_t it, output result_t r);
		logic [LEN_W-1:0]  w;
		logic [SLOT_W-1:0] old_slot;
		w = span_of(len_cfg);
		r = '0;
		if (fill >= w) begin
			// full window: drop the oldest sample, then compare with the peak
			old_slot = slot - w[SLOT_W-1:0];
			win_sum = win_sum + SUM_W'(it.sample) - SUM_W'(ring_mem[old_slot]);
			if (win_sum == peak) begin
				if (hits != '1)
					hits = hits + 1'b1;
			end else if (win_sum > peak) begin
				peak = win_sum;
				hits = CNT_W'(1);
			end
		end else begin
			win_sum = win_sum + SUM_W'(it.sample);
			fill = fill + 1'b1;
			if (fill == w) begin
				peak = win_sum;
				hits = CNT_W'(1);
			end
		end
		ring_mem[slot] = it.sample;
		slot = slot + 1'b1;
		if (!it.is_last)
			return 1'b0;
		if (fill < w) begin
			r.too_short = 1'b1;
		end else begin
			r.best_sum = peak;
			r.best_count = hits;
			r.all_zero = (peak == '0);
		end
		win_sum = '0;
		fill = '0;
		slot = '0;
		peak = '0;
		hits = '0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// monitor: sample both channels at the rising edge
	always @(posedge clk) begin : watch
		result_t want;
		item_acc = item_valid && item_ready;
		if (item_acc && advance_window(item, want))
			peaks_due.push_back(want);
		if (result_valid && result_ready) begin
			if (peaks_due.size() == 0) begin
				$display("%0t: result beat with nothing expected: sum %0d count %0d", $time,
					result.best_sum, result.best_count);
				mismatches++;
			end else begin
				want = peaks_due.pop_front();
				check_field("best_sum", CNT_W'(want.best_sum), CNT_W'(result.best_sum));
				check_field("best_count", want.best_count, result.best_count);
				check_field("all_zero", CNT_W'(want.all_zero), CNT_W'(result.all_zero));
				check_field("too_short", CNT_W'(want.too_short), CNT_W'(result.too_short));
			end
		end
	end

	// driver: hold the beat until taken, then advance
	always @(negedge clk) begin
		if (!item_valid || item_acc) begin
			if (samples_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				item <= samples_pending.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
		result_ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_window_sum_peak_counter: FAIL");
			$finish;
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		@(posedge clk);
		case (mode)
			IDLE_NONE: begin
				snd_idle_pct = 0;
				rcv_stall_pct = 0;
			end
			IDLE_SEND: begin
				snd_idle_pct = 64;
				rcv_stall_pct = 0;
			end
			IDLE_RECV: begin
				snd_idle_pct = 0;
				rcv_stall_pct = 64;
			end
			default: begin
				snd_idle_pct = 20;
				rcv_stall_pct = 20;
			end
		endcase
	endtask

	// only called with the block drained
	task automatic write_len(input logic [LEN_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		len_cfg = v;
		@(posedge clk);
	endtask

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (samples_pending.size() != 0 || item_valid || peaks_due.size() != 0);
		repeat (QUIET_TAIL) @(posedge clk);
	endtask

	task automatic queue_sample(input logic [SAMPLE_W-1:0] s, input bit last);
		item_t it;
		it.sample = s;
		it.is_last = last;
		samples_pending.push_back(it);
		queued++;
	endtask

	function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_mix_t mix);
		case (mix)
			MIX_SMALL:    return SAMPLE_W'($urandom_range(0, 2));
			MIX_ZERO:     return '0;
			MIX_EXTREME:  return $urandom_range(1) ? SAMPLE_MAX : '0;
			MIX_NEAR_MAX: return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 3));
			default:      return SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic queue_stream(input int n, input bit close, input sample_mix_t mix);
		for (int i = 0; i < n; i++)
			queue_sample(draw_sample(mix), close && (i == n - 1));
	endtask

	function automatic sample_mix_t pick_mix();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return MIX_RANDOM;
		if (r < 7)
			return MIX_SMALL;
		if (r == 7)
			return MIX_ZERO;
		if (r == 8)
			return MIX_EXTREME;
		return MIX_NEAR_MAX;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return LEN_W'($urandom_range(RING_DEPTH + 1, 2047));
		if (r == 2)
			return LEN_W'($urandom_range(65, RING_DEPTH));
		if (r < 5)
			return LEN_W'($urandom_range(9, 64));
		return LEN_W'($urandom_range(1, 8));
	endfunction

	initial begin : stimulus
		int budget;
		int done;
		int n;
		int w;
		int r;
		int phase;
		bit close;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window of one: lone zero, then a tie at full scale
		set_idle(IDLE_NONE);
		queue_sample('0, 1'b1);
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(SAMPLE_W'(1), 1'b1);
		wait_quiet();

		// window of three: short stream, all zeros, ties then a new peak
		write_len(LEN_W'(3));
		queue_sample(SAMPLE_W'(5), 1'b0);
		queue_sample(SAMPLE_W'(7), 1'b1);
		queue_stream(4, 1'b1, MIX_ZERO);
		queue_sample(SAMPLE_W'(1), 1'b0);
		queue_sample(SAMPLE_W'(2), 1'b0);
		queue_sample(SAMPLE_W'(3), 1'b0);
		queue_sample(SAMPLE_W'(1), 1'b0);
		queue_sample(SAMPLE_W'(2), 1'b0);
		queue_sample(SAMPLE_W'(3), 1'b0);
		queue_sample(SAMPLE_W'(9), 1'b1);
		wait_quiet();

		// length zero behaves as one
		write_len('0);
		queue_sample(SAMPLE_W'(3), 1'b0);
		queue_sample(SAMPLE_W'(3), 1'b0);
		queue_sample(SAMPLE_W'(2), 1'b1);
		wait_quiet();

		// oversized and full-depth windows with short streams
		write_len('1);
		queue_sample(SAMPLE_MAX, 1'b1);
		wait_quiet();
		write_len(LEN_W'(RING_DEPTH));
		queue_sample(SAMPLE_W'(1), 1'b0);
		queue_sample(SAMPLE_W'(2), 1'b1);
		wait_quiet();

		// shrink the window in mid-stream
		write_len(LEN_W'(4));
		queue_stream(4, 1'b0, MIX_SMALL);
		wait_quiet();
		write_len(LEN_W'(2));
		queue_sample(SAMPLE_W'(1), 1'b1);
		wait_quiet();

		// one stream past the ring depth, ending on a window of all full-scale samples
		write_len('1);
		queue_stream(6, 1'b0, MIX_RANDOM);
		for (int i = 0; i < RING_DEPTH; i++)
			queue_sample(SAMPLE_MAX, i == RING_DEPTH - 1);
		wait_quiet();

		// back up the output: long receiver hold-off with a result on nearly every beat
		write_len(LEN_W'(1));
		hold_go = 1'b1;
		done = 0;
		while (done < 40) begin
			n = $urandom_range(1, 2);
			queue_stream(n, 1'b1, pick_mix());
			done += n;
		end
		wait_quiet();

		phase = 0;
		while (phase < MIN_PHASES || queued < ITEM_TARGET) begin
			set_idle(idle_mode_t'(phase % 4));
			if ($urandom_range(4) != 0)
				write_len(pick_len());
			w = int'(span_of(len_cfg));
			budget = $urandom_range(20, 50);
			done = 0;
			while (done < budget) begin
				r = $urandom_range(0, 9);
				if (w > 64)
					n = $urandom_range(1, 40);
				else if (r < 2)
					n = $urandom_range(1, w);
				else if (r < 5)
					n = $urandom_range(w, w + 3);
				else
					n = $urandom_range(w + 4, 4 * w + 12);
				// sometimes leave the last stream open across the next length change
				close = !(done + n >= budget && $urandom_range(3) == 0);
				queue_stream(n, close, pick_mix());
				done += n;
			end
			wait_quiet();
			phase++;
		end

		if (mismatches == 0)
			$display("tb_window_sum_peak_counter: PASS");
		else
			$display("tb_window_sum_peak_counter: FAIL");
		$finish;
	end

endmodule
